// File: rtl/core/fsubm_pkg.sv
// Shared constants and types for the first substring match core.
`default_nettype none

package fsubm_pkg;

  // Parameter defaults
  localparam int MAX_NEEDLE_DEF    = 16;
  localparam int POSITION_BITS_DEF = 32;

  // Fixed field widths
  localparam int TEXT_W          = 8;
  localparam int OUT_POS_W       = 32;
  localparam int NEEDLE_LEN_W    = 5;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 2;
  localparam int NEEDLE_CFG_BYTES = 16;   // bytes held by the two needle registers

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NEEDLE_LOW  = 2'd0,
    REG_NEEDLE_HIGH = 2'd1,
    REG_NEEDLE_LEN  = 2'd2
  } cfg_reg_t;

  // Control of the byte held in the window stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/first_substring_match_core.sv
// Top level of the streaming first-occurrence substring search core.
//
// Usage:
//   in_*  : text bytes, one transfer per byte; in_tlast marks the last byte of a text.
//   out_* : at most one result per text. out_tuser = 1 with the start offset of the
//           first full match in out_tdata, or out_tuser = 0 with zero data when the
//           text ends without a match. A match on the last byte gives only the
//           found result. An empty needle matches at offset 0 on the first byte.
//   cfg_* : register writes (0 needle bytes 0..7, 1 needle bytes 8..15, 2 needle
//           length). cfg_ready is always high; write only while the core is idle.
// Timing:
//   One byte per cycle sustained while results are taken. Each byte is registered
//   in the window register; a result for it loads into the result register when
//   the output is free, and out_tvalid comes from that register. The compare of all
//   needle lengths against the window register sits between the input register
//   and the result register.
// Stall:
//   With the result register full and out_tready low, one more byte waits in the
//   input stage; in_tready then drops until the result is taken.
// Reset:
//   Synchronous, active low. Clears the needle registers, the pipeline valids, the
//   byte count and the match flag. No clearing pass is needed.
`default_nettype none

module first_substring_match_core #(
  parameter int MAX_NEEDLE    = fsubm_pkg::MAX_NEEDLE_DEF,
  parameter int POSITION_BITS = fsubm_pkg::POSITION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // text byte stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [7:0] text_byte
  input  wire logic                                in_tlast,   // last_byte
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [31:0]                              out_tdata,  // [31:0] match_position
  output logic                                     out_tuser,  // found
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fsubm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [fsubm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fsubm_pkg::*;

  // Needle registers
  logic [CFG_DATA_W-1:0]   needle_lo_r, needle_hi_r;
  logic [NEEDLE_LEN_W-1:0] needle_len_r;
  logic                    cfg_write;

  // Window stage to compare stage
  stage_ctl_t                   s1_ctl;
  logic [MAX_NEEDLE*TEXT_W-1:0] s1_window;
  logic [POSITION_BITS-1:0]     s1_idx;
  logic                         advance;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Index 3 is not a register; such writes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_lo_r  <= '0;
      needle_hi_r  <= '0;
      needle_len_r <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NEEDLE_LOW:  needle_lo_r  <= cfg_data;
        REG_NEEDLE_HIGH: needle_hi_r  <= cfg_data;
        REG_NEEDLE_LEN:  needle_len_r <= cfg_data[NEEDLE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  fsubm_window #(
    .MAX_NEEDLE    (MAX_NEEDLE),
    .POSITION_BITS (POSITION_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .advance  (advance),
    .in_ready (in_tready),
    .ctl      (s1_ctl),
    .window   (s1_window),
    .idx      (s1_idx)
  );

  fsubm_match #(
    .MAX_NEEDLE    (MAX_NEEDLE),
    .POSITION_BITS (POSITION_BITS)
  ) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (s1_ctl),
    .window     (s1_window),
    .idx        (s1_idx),
    .needle     ({needle_hi_r, needle_lo_r}),
    .needle_len (needle_len_r),
    .out_ready  (out_tready),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_found  (out_tuser),
    .out_pos    (out_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/fsubm_window.sv
// Input stage: byte window shift register and per-text byte counter.
`default_nettype none

module fsubm_window #(
  parameter int MAX_NEEDLE    = fsubm_pkg::MAX_NEEDLE_DEF,
  parameter int POSITION_BITS = fsubm_pkg::POSITION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic [fsubm_pkg::TEXT_W-1:0]      in_byte,
  input  wire logic                              in_last,
  input  wire logic                              advance,
  output logic                                   in_ready,
  output fsubm_pkg::stage_ctl_t                  ctl,
  output logic [MAX_NEEDLE*fsubm_pkg::TEXT_W-1:0] window,
  output logic [POSITION_BITS-1:0]               idx
);
  import fsubm_pkg::*;

  localparam int WinW = MAX_NEEDLE * TEXT_W;

  logic                     valid_r, valid_nxt;
  logic                     last_r;
  logic                     prev_last_r;   // previous transfer closed a text
  logic [POSITION_BITS-1:0] seen_r, seen_nxt;
  logic [POSITION_BITS-1:0] idx_r, base_cnt;
  logic [WinW-1:0]          win_r, win_nxt;
  logic                     accept;

  assign in_ready = !valid_r || advance;
  assign accept   = in_valid && in_ready;

  // Stale bytes from an earlier text are never compared: a length-k match
  // needs at least k bytes of the current text, so the window is not cleared.
  always_comb begin
    win_nxt                = win_r << TEXT_W;
    win_nxt[TEXT_W-1:0]    = in_byte;
    base_cnt               = prev_last_r ? '0 : seen_r;
    seen_nxt               = (base_cnt == '1) ? base_cnt : base_cnt + 1'b1;
    valid_nxt              = accept ? 1'b1 : (advance ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      prev_last_r <= 1'b1;
      seen_r      <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        prev_last_r <= in_last;
        seen_r      <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r  <= win_nxt;
      idx_r  <= base_cnt;
      last_r <= in_last;
    end
  end

  assign ctl.valid = valid_r;
  assign ctl.last  = last_r;
  assign window    = win_r;
  assign idx       = idx_r;

endmodule

`default_nettype wire

// File: rtl/core/fsubm_match.sv
// Match stage: needle compare for every length, first-match flag, result register.
`default_nettype none

module fsubm_match #(
  parameter int MAX_NEEDLE    = fsubm_pkg::MAX_NEEDLE_DEF,
  parameter int POSITION_BITS = fsubm_pkg::POSITION_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire fsubm_pkg::stage_ctl_t                  ctl,
  input  wire logic [MAX_NEEDLE*fsubm_pkg::TEXT_W-1:0] window,
  input  wire logic [POSITION_BITS-1:0]               idx,
  input  wire logic [fsubm_pkg::NEEDLE_CFG_BYTES*fsubm_pkg::TEXT_W-1:0] needle,
  input  wire logic [fsubm_pkg::NEEDLE_LEN_W-1:0]     needle_len,
  input  wire logic                                   out_ready,
  output logic                                        advance,
  output logic                                        out_valid,
  output logic                                        out_found,
  output logic [fsubm_pkg::OUT_POS_W-1:0]             out_pos
);
  import fsubm_pkg::*;

  localparam int CalcW = (POSITION_BITS + 1 > OUT_POS_W) ? POSITION_BITS + 1 : OUT_POS_W + 1;

  logic [MAX_NEEDLE*TEXT_W-1:0] needle_ext;
  logic [MAX_NEEDLE:0]          len_hit;
  logic                         hit_k;
  logic [CalcW-1:0]             idx_inc, k_ext, pos_full;
  logic                         len_ok, not_sat, match_hit, produce;
  logic                         reported_r, reported_nxt;
  logic                         valid_r, valid_nxt;
  logic                         found_r;
  logic [OUT_POS_W-1:0]         pos_r, pos_val;

  // Needle bytes past the configured sixteen read as zero.
  genvar i, j;
  generate
    for (i = 0; i < MAX_NEEDLE; i++) begin : g_ndl
      if (i < NEEDLE_CFG_BYTES) begin : g_cfg
        assign needle_ext[i*TEXT_W +: TEXT_W] = needle[i*TEXT_W +: TEXT_W];
      end else begin : g_zero
        assign needle_ext[i*TEXT_W +: TEXT_W] = '0;
      end
    end

    // len_hit[j]: the newest j bytes equal needle bytes 0..j-1 (oldest first)
    assign len_hit[0] = 1'b1;
    for (j = 1; j <= MAX_NEEDLE; j++) begin : g_len
      logic [j-1:0] eq;
      for (i = 0; i < j; i++) begin : g_byte
        assign eq[i] = window[(j-1-i)*TEXT_W +: TEXT_W] == needle_ext[i*TEXT_W +: TEXT_W];
      end
      assign len_hit[j] = &eq;
    end
  endgenerate

  always_comb begin
    // lengths above MAX_NEEDLE select nothing and never match
    hit_k = 1'b0;
    for (int n = 0; n <= MAX_NEEDLE; n++) begin
      if (int'(needle_len) == n) hit_k = len_hit[n];
    end
    idx_inc  = CalcW'(idx) + 1'b1;
    k_ext    = CalcW'(needle_len);
    len_ok   = idx_inc >= k_ext;
    pos_full = idx_inc - k_ext;
    pos_val  = (needle_len == '0) ? '0 : pos_full[OUT_POS_W-1:0];
    not_sat  = idx != '1;

    match_hit = ctl.valid && !reported_r && not_sat && hit_k && len_ok;
    produce   = match_hit || (ctl.valid && ctl.last && !reported_r);

    advance   = ctl.valid && (!valid_r || out_ready);

    reported_nxt = reported_r;
    if (advance) reported_nxt = ctl.last ? 1'b0 : (reported_r || match_hit);

    valid_nxt = (advance && produce) ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      reported_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      reported_r <= reported_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      found_r <= match_hit;
      pos_r   <= match_hit ? pos_val : '0;
    end
  end

  assign out_valid = valid_r;
  assign out_found = found_r;
  assign out_pos   = pos_r;

endmodule

`default_nettype wire

// File: rtl/core/fsubm_checker.sv
// Port-level checks for the first substring match core, bound to the top level.
`default_nettype none

module fsubm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  // A not-found result carries a zero offset.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0)
    else $error("not-found result with nonzero position");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A free output side never throttles the input.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output side is ready");

endmodule

bind first_substring_match_core fsubm_checker u_fsubm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: dv/fsubm_checker.sv
// Scoreboard for the substring search core: tracks needle writes, predicts and checks results.
`timescale 1ns / 100ps

module fsubm_scoreboard
  import fsubm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [TEXT_W-1:0]      in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_POS_W-1:0]   out_tdata,
  input  logic                   out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     results_pending
);

  localparam int WIN = MAX_NEEDLE_DEF;
  localparam int POS_W = POSITION_BITS_DEF;
  localparam logic [POS_W-1:0] SEEN_MAX = '1;

  typedef struct packed {
    logic                 found;
    logic [OUT_POS_W-1:0] position;
  } search_outcome_t;

  logic [CFG_DATA_W-1:0]   needle_lo;
  logic [CFG_DATA_W-1:0]   needle_hi;
  logic [NEEDLE_LEN_W-1:0] needle_len;
  logic [TEXT_W-1:0]       window [WIN];
  logic [POS_W-1:0]        seen;
  logic                    reported;
  search_outcome_t         search_outcomes_q [$];

  function automatic logic [7:0] needle_byte(input int i);
    if (i < 8) return needle_lo[8*i +: 8];
    if (i < 16) return needle_hi[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  task automatic clear_text();
    for (int j = 0; j < WIN; j++) window[j] = '0;
    seen = '0;
    reported = 1'b0;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // One text byte: shift the window, look for the first full match, close the text on tlast.
  task automatic take_text_byte(input logic [TEXT_W-1:0] b, input logic last);
    logic hit;
    logic [POS_W:0] span;
    logic [POS_W:0] pos;
    int k;
    hit = 1'b0;
    pos = '0;
    k = needle_len;
    for (int j = WIN - 1; j > 0; j--) window[j] = window[j-1];
    window[0] = b;
    if (!reported && seen != SEEN_MAX && k <= WIN) begin
      span = {1'b0, seen} + 1'b1;
      if (k == 0) begin
        hit = 1'b1;
      end else if (span >= k) begin
        hit = 1'b1;
        for (int i = 0; i < k; i++)
          if (window[k-1-i] != needle_byte(i)) hit = 1'b0;
        pos = span - k;
      end
      if (hit) begin
        reported = 1'b1;
        search_outcomes_q.push_back('{found: 1'b1, position: pos[OUT_POS_W-1:0]});
      end
    end
    if (seen != SEEN_MAX) seen++;
    if (last) begin
      if (!reported) search_outcomes_q.push_back('{found: 1'b0, position: '0});
      clear_text();
    end
  endtask

  always @(posedge clk) begin
    search_outcome_t exp_r;
    if (!rst_n) begin
      needle_lo = '0;
      needle_hi = '0;
      needle_len = '0;
      clear_text();
      search_outcomes_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NEEDLE_LOW:  needle_lo = cfg_data;
          REG_NEEDLE_HIGH: needle_hi = cfg_data;
          REG_NEEDLE_LEN:  needle_len = cfg_data[NEEDLE_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) take_text_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (search_outcomes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result found=%0d position=%0d",
                                    out_tuser, out_tdata));
        end else begin
          exp_r = search_outcomes_q.pop_front();
          if (out_tuser !== exp_r.found)
            report_mismatch($sformatf("found %0d, expected %0d", out_tuser, exp_r.found));
          if (out_tdata !== exp_r.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      out_tdata, exp_r.position));
        end
      end
    end
    results_pending = search_outcomes_q.size();
  end

endmodule

// File: dv/tb.sv
// Testbench top for the substring search core: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import fsubm_pkg::*;

  localparam int RANDOM_BYTES   = 1400;
  localparam int IDLE_PCT       = 31;
  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 6;     // pads the drain of the core's window and result registers
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on any channel
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;  // no register here

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [TEXT_W-1:0]      in_tdata = '0;    // [7:0] text_byte
  logic                   in_tlast = 1'b0;  // last_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_POS_W-1:0]   out_tdata;        // [31:0] match_position
  logic                   out_tuser;        // found
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatch_count;
  int results_pending;

  // stimulus-side copy of the needle, used only to shape text content
  logic [127:0]            cur_pattern = '0;
  logic [NEEDLE_LEN_W-1:0] cur_len = '0;

  bit idle_on = 1'b1;   // random gaps on both sides
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off

  int quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  first_substring_match_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fsubm_scoreboard chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // Watchdog: a stuck handshake anywhere ends the run as a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request so the
  // result register and the input stage both fill and in_tready drops.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Stream one text, tlast on its final byte. Leaves in_tvalid high on return so
  // back-to-back texts go out with no bubble; settle() lowers it.
  task automatic send_text(input logic [7:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++) begin
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= bytes[i];
      in_tlast  <= (i == bytes.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending, wait for every outstanding result, then let trailing bytes
  // that produce no result drain out of the pipeline.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_needle(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [NEEDLE_LEN_W-1:0] len);
    settle();
    write_reg(REG_NEEDLE_LOW, lo);
    write_reg(REG_NEEDLE_HIGH, hi);
    write_reg(REG_NEEDLE_LEN, {{(CFG_DATA_W-NEEDLE_LEN_W){1'b0}}, len});
    cur_pattern = {hi, lo};
    cur_len = len;
  endtask

  // Random text: mostly needle bytes so partial and overlapping matches are
  // common, sometimes with the whole needle planted at a random offset.
  task automatic send_random_text(input int max_len, inout int sent);
    logic [7:0] text_q[$];
    int tl;
    int n_used;
    int at;
    tl = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, max_len);
    n_used = (cur_len > 16) ? 16 : cur_len;
    for (int i = 0; i < tl; i++) begin
      if (n_used != 0 && $urandom_range(0, 99) < 75)
        text_q.push_back(cur_pattern[8*$urandom_range(0, n_used-1) +: 8]);
      else
        text_q.push_back(8'($urandom_range(0, 255)));
    end
    if (cur_len != 0 && cur_len <= 16 && tl >= cur_len && $urandom_range(0, 1) == 1) begin
      at = $urandom_range(0, tl - cur_len);
      for (int i = 0; i < cur_len; i++) text_q[at+i] = cur_pattern[8*i +: 8];
    end
    send_text(text_q);
    sent += tl;
  endtask

  initial begin
    logic [7:0]  text_q[$];
    logic [127:0] pat;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;
    logic [NEEDLE_LEN_W-1:0] len;
    int sent;
    int phase;
    int texts;
    int mode;

    sent = 0;
    phase = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // Empty needle straight out of reset: single-byte text, match at offset 0.
    text_q = {8'h00};
    send_text(text_q);

    // Two-byte needle FF 00: match on the final byte, text shorter than the
    // needle, and a match followed by more bytes that must stay silent.
    set_needle(64'h0000_0000_0000_00FF, 64'h0, 5'd2);
    text_q = {8'hFF, 8'h00};
    send_text(text_q);
    text_q = {8'hFF};
    send_text(text_q);
    text_q = {8'h01, 8'hFF, 8'h00, 8'hFF};
    send_text(text_q);

    // Full-length needle; a write to the unused index must change nothing.
    set_needle({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
    write_reg(REG_UNUSED, '1);
    text_q.delete();
    for (int i = 0; i < 16; i++) text_q.push_back(cur_pattern[8*i +: 8]);
    send_text(text_q);

    // Needle length beyond the window: never matches.
    set_needle({$urandom, $urandom}, {$urandom, $urandom}, 5'd20);
    text_q = {8'hAA, 8'h55};
    send_text(text_q);

    // ---- random part ----
    while (sent < RANDOM_BYTES) begin
      mode = $urandom_range(0, 9);
      pat = {$urandom, $urandom, $urandom, $urandom};
      if (phase == 0) begin
        pat = '1;            // extreme: all-ones registers, full length
        len = 5'd16;
      end else if (phase == 1) begin
        pat = '0;            // extreme: all-zero needle, full length
        len = 5'd16;
      end else if (mode == 0) begin
        len = 5'd0;
      end else if (mode == 1) begin
        len = 5'd16;
      end else if (mode == 2) begin
        len = 5'($urandom_range(17, 31));
      end else begin
        // short needle over a two-symbol alphabet: lots of near misses
        len = 5'($urandom_range(1, 6));
        sym_a = 8'($urandom_range(0, 255));
        sym_b = 8'($urandom_range(0, 255));
        for (int i = 0; i < 16; i++) pat[8*i +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
      end
      set_needle(pat[63:0], pat[127:64], len);

      idle_on = !(phase == 2 || phase == 9);
      if (phase == 3) begin
        // receiver stalls while many short texts keep coming
        hold_req = 1'b1;
        for (int t = 0; t < 20; t++) send_random_text(3, sent);
      end else begin
        texts = $urandom_range(3, 8);
        for (int t = 0; t < texts; t++) send_random_text(24, sent);
      end
      phase++;
    end

    idle_on = 1'b1;
    settle();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/fsubm_pkg.sv
rtl/core/fsubm_window.sv
rtl/core/fsubm_match.sv
rtl/core/first_substring_match_core.sv
rtl/core/fsubm_checker.sv
dv/fsubm_checker.sv
dv/tb.sv
